>>> rtl/ehp_pkg.sv
// Shared types, constants and helpers for the Ethernet header parser.
`default_nettype none

package ehp_pkg;

	localparam int unsigned MAX_FRAME_BYTES_DEF = 65535;
	localparam int unsigned QUEUE_DEPTH_DEF     = 4;

	localparam logic [15:0] TYPE_IPV4 = 16'h0800;
	localparam logic [15:0] TYPE_ARP  = 16'h0806;
	localparam logic [15:0] TYPE_IPV6 = 16'h86DD;

	localparam logic [15:0] LEN_LIMIT = 16'd1500;
	localparam logic [15:0] ARP_LEN   = 16'd28;
	localparam logic [15:0] DEST_END  = 16'd6;
	localparam logic [15:0] SRC_END   = 16'd12;
	localparam logic [15:0] TYPE_LAST = 16'd13;
	localparam logic [15:0] HDR_LEN   = 16'd14;
	localparam logic [15:0] HOLD_CNT  = 16'd3;

	localparam int NUM_PAY   = 4;
	localparam int NUM_SLOTS = NUM_PAY + 2;
	localparam int SEL_W     = $clog2(NUM_SLOTS);
	localparam int SLOT_HDR  = 0;
	localparam int SLOT_PAY0 = 1;
	localparam int SLOT_STAT = NUM_SLOTS - 1;

	typedef enum logic [1:0] {
		KIND_HEADER  = 2'd0,
		KIND_PAYLOAD = 2'd1,
		KIND_STATUS  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_SHORT = 2'd1,
		ST_TRUNC = 2'd2,
		ST_UNSUP = 2'd3
	} status_t;

	typedef struct packed {
		logic [NUM_SLOTS-1:0]      slot_v;
		logic [47:0]               dest;
		logic [47:0]               src;
		logic [15:0]               etype;
		logic [NUM_PAY-1:0][7:0]   pay;
		logic [NUM_PAY-1:0]        pay_last;
		status_t                   status;
	} cmd_t;

	function automatic logic type_supported(input logic [15:0] t);
		return (t <= LEN_LIMIT) || (t == TYPE_IPV4) || (t == TYPE_ARP) || (t == TYPE_IPV6);
	endfunction

endpackage

`default_nettype wire

>>> rtl/ehp_front.sv
// Front end: accepts frame bytes, tracks header and length, builds result commands.
`default_nettype none

module ehp_front import ehp_pkg::*; #(
	parameter int unsigned MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] data_byte,
	input  wire logic       frame_end,
	output logic            push_valid,
	input  wire logic       push_ready,
	output cmd_t            cmd
);

	logic [15:0] pos_q, pos_n;
	logic [47:0] dest_q, dest_n;
	logic [47:0] src_q, src_n;
	logic [15:0] type_q, type_n;
	logic [15:0] len_q, len_n;
	logic [15:0] sent_q, sent_n;
	logic        known_q, known_n;
	logic [7:0]  held_q [3];

	logic                    active;
	logic                    accept;
	logic [15:0]             p;
	logic                    hold_wr;
	logic [NUM_PAY-1:0][7:0] cand;
	logic [1:0]              last_idx;
	logic                    any_pay;

	assign active   = pos_q < 16'(MAX_FRAME_BYTES);
	assign p        = pos_q - HDR_LEN;
	assign in_ready = push_ready;
	assign accept   = in_valid && in_ready;
	assign hold_wr  = active && (pos_q >= HDR_LEN) && !known_q && (p < HOLD_CNT);
	assign cand     = {data_byte, held_q[2], held_q[1], held_q[0]};

	always_comb begin
		pos_n    = pos_q;
		dest_n   = dest_q;
		src_n    = src_q;
		type_n   = type_q;
		len_n    = len_q;
		sent_n   = sent_q;
		known_n  = known_q;
		cmd      = '0;
		last_idx = '0;
		any_pay  = 1'b0;
		if (active) begin
			pos_n = pos_q + 16'd1;
			if (pos_q < DEST_END) begin
				dest_n = {dest_q[39:0], data_byte};
			end else if (pos_q < SRC_END) begin
				src_n = {src_q[39:0], data_byte};
			end else if (pos_q < HDR_LEN) begin
				type_n = {type_q[7:0], data_byte};
				if (pos_q == TYPE_LAST) begin
					if (type_n <= LEN_LIMIT) begin
						len_n   = type_n;
						known_n = 1'b1;
					end else if (type_n == TYPE_IPV4) begin
						len_n   = '0;
						known_n = 1'b0;
					end else if (type_n == TYPE_ARP) begin
						len_n   = ARP_LEN;
						known_n = 1'b1;
					end else begin
						len_n   = '0;
						known_n = 1'b1;
					end
					cmd.slot_v[SLOT_HDR] = 1'b1;
					cmd.dest             = dest_q;
					cmd.src              = src_q;
					cmd.etype            = type_n;
				end
			end else if (!known_q) begin
				if (p == HOLD_CNT) begin
					len_n   = {held_q[2], data_byte};
					known_n = 1'b1;
					for (int i = 0; i < NUM_PAY; i++) begin
						if (16'(i) < len_n) begin
							cmd.slot_v[SLOT_PAY0+i] = 1'b1;
							cmd.pay[i]              = cand[i];
							cmd.pay_last[i]         = (16'(i + 1) == len_n);
						end
					end
					sent_n = sent_q + 16'($countones(cmd.slot_v[SLOT_PAY0 +: NUM_PAY]));
				end
			end else if (p < len_q) begin
				cmd.slot_v[SLOT_PAY0] = 1'b1;
				cmd.pay[0]            = data_byte;
				cmd.pay_last[0]       = (p + 16'd1 == len_q);
				sent_n                = sent_q + 16'd1;
			end
		end
		if (frame_end) begin
			for (int i = 0; i < NUM_PAY; i++) begin
				if (cmd.slot_v[SLOT_PAY0+i]) begin
					last_idx = 2'(i);
					any_pay  = 1'b1;
				end
			end
			if (any_pay) begin
				cmd.pay_last[last_idx] = 1'b1;
			end
			if (pos_n < HDR_LEN) begin
				cmd.status = ST_SHORT;
			end else if (!type_supported(type_n)) begin
				cmd.status = ST_UNSUP;
			end else if (!known_n || (sent_n < len_n)) begin
				cmd.status = ST_TRUNC;
			end else begin
				cmd.status = ST_OK;
			end
			cmd.slot_v[SLOT_STAT] = 1'b1;
			pos_n   = '0;
			dest_n  = '0;
			src_n   = '0;
			type_n  = '0;
			len_n   = '0;
			sent_n  = '0;
			known_n = 1'b0;
		end
	end

	assign push_valid = in_valid && (|cmd.slot_v);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			dest_q  <= '0;
			src_q   <= '0;
			type_q  <= '0;
			len_q   <= '0;
			sent_q  <= '0;
			known_q <= 1'b0;
		end else if (accept) begin
			pos_q   <= pos_n;
			dest_q  <= dest_n;
			src_q   <= src_n;
			type_q  <= type_n;
			len_q   <= len_n;
			sent_q  <= sent_n;
			known_q <= known_n;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && hold_wr) begin
			held_q[p[1:0]] <= data_byte;
		end
	end

	a_hdr_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(pos_q < HDR_LEN) |-> (sent_q == 16'd0 && !known_q && len_q == 16'd0))
		else $error("frame state set before header completed");

	a_hdr_no_pay: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid |-> !(cmd.slot_v[SLOT_HDR] && (|cmd.slot_v[SLOT_PAY0 +: NUM_PAY])))
		else $error("header and payload in one command");

endmodule

`default_nettype wire

>>> rtl/ehp_queue.sv
// Command queue between the front end and the result sequencer.
`default_nettype none

module ehp_queue import ehp_pkg::*; #(
	parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push_valid,
	output logic      push_ready,
	input  cmd_t      push_data,
	output logic      pop_valid,
	input  wire logic pop,
	output cmd_t      pop_data
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;

	assign push_ready = count_q != CNT_W'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count overflow");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("pop from empty queue");

endmodule

`default_nettype wire

>>> rtl/ehp_back.sv
// Back end: walks each queued command and issues its results one per cycle while out_ready does not stall the output.
`default_nettype none

module ehp_back import ehp_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  cmd_t        head,
	input  wire logic   head_valid,
	output logic        pop,
	output logic        out_valid,
	input  wire logic   out_ready,
	output logic [1:0]  kind,
	output logic [47:0] dest_addr,
	output logic [47:0] src_addr,
	output logic [15:0] type_field,
	output logic [7:0]  payload_byte,
	output logic        payload_last,
	output logic [1:0]  status,
	output logic        run_last
);

	logic [NUM_SLOTS-1:0] done_q;
	logic [NUM_SLOTS-1:0] remaining;
	logic [NUM_SLOTS-1:0] pick;
	logic [SEL_W-1:0]     sel;
	logic [1:0]           pidx;
	logic                 is_final;
	logic                 load;

	logic                 out_valid_q;
	kind_t                kind_q;
	logic [47:0]          dest_q;
	logic [47:0]          src_q;
	logic [15:0]          type_q;
	logic [7:0]           pay_q;
	logic                 pay_last_q;
	status_t              status_q;
	logic                 run_last_q;

	always_comb begin
		remaining = head.slot_v & ~done_q;
		sel       = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (remaining[i]) begin
				sel = SEL_W'(i);
			end
		end
		pick     = NUM_SLOTS'(1) << sel;
		is_final = (remaining & ~pick) == '0;
		pidx     = 2'(sel - SEL_W'(SLOT_PAY0));
	end

	assign load = head_valid && (!out_valid_q || out_ready);
	assign pop  = load && is_final;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			done_q      <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				done_q      <= is_final ? '0 : (done_q | pick);
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			run_last_q <= is_final;
			dest_q     <= '0;
			src_q      <= '0;
			type_q     <= '0;
			pay_q      <= '0;
			pay_last_q <= 1'b0;
			status_q   <= ST_OK;
			if (sel == SEL_W'(SLOT_HDR)) begin
				kind_q <= KIND_HEADER;
				dest_q <= head.dest;
				src_q  <= head.src;
				type_q <= head.etype;
			end else if (sel == SEL_W'(SLOT_STAT)) begin
				kind_q   <= KIND_STATUS;
				status_q <= head.status;
			end else begin
				kind_q     <= KIND_PAYLOAD;
				pay_q      <= head.pay[pidx];
				pay_last_q <= head.pay_last[pidx];
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign dest_addr    = dest_q;
	assign src_addr     = src_q;
	assign type_field   = type_q;
	assign payload_byte = pay_q;
	assign payload_last = pay_last_q;
	assign status       = status_q;
	assign run_last     = run_last_q;

	a_idle_done_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!head_valid |-> (done_q == '0))
		else $error("progress mask left without a command");

	a_done_subset: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> ((done_q & ~head.slot_v) == '0 && remaining != '0))
		else $error("progress mask out of step with command");

endmodule

`default_nettype wire

>>> rtl/ethernet_header_parser_top.sv
// Top level of the Ethernet II header parser: front end, command queue, result sequencer.
// Each result is registered in the command queue and then in the sequencer's output register.
// Throughput: one byte per cycle while each byte causes at most one result
// and the queue has room; a byte can cause up to five results, and the queue absorbs bursts.
// Reset (arst_n low) clears frame state, the queue count and the output valid flag at once.
`default_nettype none

module ethernet_header_parser_top import ehp_pkg::*; #(
	parameter int unsigned MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF,
	parameter int unsigned QUEUE_DEPTH     = QUEUE_DEPTH_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] data_byte,
	input  wire logic       frame_end,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [1:0]      kind,
	output logic [47:0]     dest_addr,
	output logic [47:0]     src_addr,
	output logic [15:0]     type_field,
	output logic [7:0]      payload_byte,
	output logic            payload_last,
	output logic [1:0]      status,
	output logic            run_last
);

	cmd_t push_cmd;
	cmd_t head_cmd;
	logic push_valid;
	logic push_ready;
	logic head_valid;
	logic pop;

	ehp_front #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.frame_end (frame_end),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.cmd       (push_cmd)
	);

	ehp_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_cmd),
		.pop_valid (head_valid),
		.pop       (pop),
		.pop_data  (head_cmd)
	);

	ehp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head_cmd),
		.head_valid  (head_valid),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.kind        (kind),
		.dest_addr   (dest_addr),
		.src_addr    (src_addr),
		.type_field  (type_field),
		.payload_byte(payload_byte),
		.payload_last(payload_last),
		.status      (status),
		.run_last    (run_last)
	);

endmodule

`default_nettype wire
